// File: src/v4au_pkg.sv
`timescale 1ns / 1ps

package v4au_pkg;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_DIV   = 3'd2,
        CMD_SCALE = 3'd3,
        CMD_DOT   = 3'd4,
        CMD_MAG   = 3'd5,
        CMD_NORM  = 3'd6
    } t_cmd;

endpackage

// File: src/v4au_lane.sv
`timescale 1ns / 1ps

module v4au_lane #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  v4au_pkg::t_cmd       i_cmd,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    input  logic [W-1:0]         i_scl,
    output logic [W-1:0]         o_addsub,
    output logic                 o_addsub_ovf,
    output logic [2*W-1:0]       o_prod,
    output logic                 o_prod_neg,
    output logic [W-1:0]         o_a_mag,
    output logic                 o_a_neg,
    output logic [W-1:0]         o_b_mag,
    output logic                 o_b_neg
);

    localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]   n_a_mag, n_b_mag, s_mag, op;
    logic           n_a_neg, n_b_neg, op_neg;
    logic [W:0]     t;
    logic [W-1:0]   n_addsub;
    logic           n_addsub_ovf;
    logic [2*W-1:0] n_prod;
    logic           n_prod_neg;

    logic [W-1:0]   r_addsub, r_a_mag, r_b_mag;
    logic           r_addsub_ovf, r_prod_neg, r_a_neg, r_b_neg;
    logic [2*W-1:0] r_prod;

    always_comb begin
        n_a_neg = i_a[W-1];
        n_b_neg = i_b[W-1];
        n_a_mag = n_a_neg ? (~i_a + 1'b1) : i_a;
        n_b_mag = n_b_neg ? (~i_b + 1'b1) : i_b;
        s_mag   = i_scl[W-1] ? (~i_scl + 1'b1) : i_scl;

        if (i_cmd == v4au_pkg::CMD_SUB) begin
            t = {i_a[W-1], i_a} - {i_b[W-1], i_b};
        end else begin
            t = {i_a[W-1], i_a} + {i_b[W-1], i_b};
        end
        if (t[W] != t[W-1]) begin
            n_addsub_ovf = 1'b1;
            n_addsub     = t[W] ? MIN_V : MAX_V;
        end else begin
            n_addsub_ovf = 1'b0;
            n_addsub     = t[W-1:0];
        end

        case (i_cmd)
            v4au_pkg::CMD_DOT: begin
                op     = n_b_mag;
                op_neg = n_b_neg;
            end
            v4au_pkg::CMD_SCALE: begin
                op     = s_mag;
                op_neg = i_scl[W-1];
            end
            v4au_pkg::CMD_MAG, v4au_pkg::CMD_NORM: begin
                op     = n_a_mag;
                op_neg = n_a_neg;
            end
            default: begin
                op     = '0;
                op_neg = 1'b0;
            end
        endcase
        n_prod     = {{W{1'b0}}, n_a_mag} * {{W{1'b0}}, op};
        n_prod_neg = n_a_neg ^ op_neg;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_addsub     <= n_addsub;
            r_addsub_ovf <= n_addsub_ovf;
            r_prod       <= n_prod;
            r_prod_neg   <= n_prod_neg;
            r_a_mag      <= n_a_mag;
            r_a_neg      <= n_a_neg;
            r_b_mag      <= n_b_mag;
            r_b_neg      <= n_b_neg;
        end
    end

    assign o_addsub     = r_addsub;
    assign o_addsub_ovf = r_addsub_ovf;
    assign o_prod       = r_prod;
    assign o_prod_neg   = r_prod_neg;
    assign o_a_mag      = r_a_mag;
    assign o_a_neg      = r_a_neg;
    assign o_b_mag      = r_b_mag;
    assign o_b_neg      = r_b_neg;

endmodule

// File: src/v4au_merge.sv
`timescale 1ns / 1ps

module v4au_merge #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  v4au_pkg::t_cmd        i_cmd,
    input  logic [3:0][W-1:0]     i_addsub,
    input  logic [3:0]            i_addsub_ovf,
    input  logic [3:0][2*W-1:0]   i_prod,
    input  logic [3:0]            i_prod_neg,
    output logic [3:0][W-1:0]     o_pre,
    output logic [W-1:0]          o_scal,
    output logic                  o_ovf,
    output logic [2*W+1:0]        o_sumsq
);

    localparam int DW = 2 * W + 3;
    localparam logic [DW-1:0] LIM_POS = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [DW-1:0] LIM_NEG = LIM_POS + 1'b1;

    function automatic logic [W:0] f_sat(input logic [DW-1:0] m, input logic neg);
        logic [DW-1:0] lim;
        logic [DW-1:0] mm;
        logic          ovf;
        lim = neg ? LIM_NEG : LIM_POS;
        ovf = (m > lim);
        mm  = ovf ? lim : m;
        return {ovf, neg ? (~mm[W-1:0] + 1'b1) : mm[W-1:0]};
    endfunction

    logic [DW-1:0]        acc, term, dmag;
    logic                 dneg;
    logic [W:0]           dres;
    logic [3:0][W:0]      sres;
    logic [2*W+1:0]       n_sumsq;
    logic [3:0][W-1:0]    n_pre;
    logic [W-1:0]         n_scal;
    logic                 n_ovf;

    logic [3:0][W-1:0]    r_pre;
    logic [W-1:0]         r_scal;
    logic                 r_ovf;
    logic [2*W+1:0]       r_sumsq;

    always_comb begin
        acc     = '0;
        n_sumsq = '0;
        for (int l = 0; l < 4; l++) begin
            term    = {3'b000, i_prod[l]};
            acc     = i_prod_neg[l] ? (acc - term) : (acc + term);
            n_sumsq = n_sumsq + {2'b00, i_prod[l]};
            sres[l] = f_sat(term >> F, i_prod_neg[l]);
        end
        dneg = acc[DW-1];
        dmag = dneg ? (~acc + 1'b1) : acc;
        dres = f_sat(dmag >> F, dneg);

        n_pre  = '0;
        n_scal = '0;
        n_ovf  = 1'b0;
        case (i_cmd)
            v4au_pkg::CMD_ADD, v4au_pkg::CMD_SUB: begin
                n_pre = i_addsub;
                n_ovf = |i_addsub_ovf;
            end
            v4au_pkg::CMD_SCALE: begin
                for (int l = 0; l < 4; l++) begin
                    n_pre[l] = sres[l][W-1:0];
                    n_ovf    = n_ovf | sres[l][W];
                end
            end
            v4au_pkg::CMD_DOT: begin
                n_scal = dres[W-1:0];
                n_ovf  = dres[W];
            end
            default: begin
                n_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre   <= n_pre;
            r_scal  <= n_scal;
            r_ovf   <= n_ovf;
            r_sumsq <= n_sumsq;
        end
    end

    assign o_pre   = r_pre;
    assign o_scal  = r_scal;
    assign o_ovf   = r_ovf;
    assign o_sumsq = r_sumsq;

endmodule

// File: src/v4au_sqrt.sv
`timescale 1ns / 1ps

module v4au_sqrt #(
    parameter int RB = 33,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2*RB-1:0]   i_x,
    input  logic [SW-1:0]     i_side,
    output logic [RB-1:0]     o_root,
    output logic [SW-1:0]     o_side
);

    logic [RB:0]     r_rem  [RB-1];
    logic [2*RB-1:0] r_x    [RB-1];
    logic [RB-1:0]   r_root [RB];
    logic [SW-1:0]   r_side [RB];

    genvar g;
    generate
        for (g = 0; g < RB; g++) begin : g_step
            logic [RB:0]     rem_in;
            logic [RB-1:0]   root_in;
            logic [2*RB-1:0] x_in;
            logic [SW-1:0]   side_in;
            logic [RB+2:0]   t, trial, diff;
            logic            ge;
            logic [RB:0]     n_rem;

            if (g == 0) begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign x_in    = i_x;
                assign side_in = i_side;
            end else begin : g_next
                assign rem_in  = r_rem[g-1];
                assign root_in = r_root[g-1];
                assign x_in    = r_x[g-1];
                assign side_in = r_side[g-1];
            end

            always_comb begin
                t     = {rem_in, x_in[2*RB-1 -: 2]};
                trial = {1'b0, root_in, 2'b01};
                diff  = t - trial;
                ge    = (t >= trial);
                n_rem = ge ? diff[RB:0] : t[RB:0];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_root[g] <= {root_in[RB-2:0], ge};
                    r_side[g] <= side_in;
                end
            end

            if (g < RB - 1) begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[g] <= n_rem;
                        r_x[g]   <= {x_in[2*RB-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[RB-1];
    assign o_side = r_side[RB-1];

endmodule

// File: src/v4au_div.sv
`timescale 1ns / 1ps

module v4au_div #(
    parameter int QB = 48,
    parameter int DB = 33,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [3:0][QB-1:0]   i_num,
    input  logic [3:0][DB-1:0]   i_den,
    input  logic [SW-1:0]        i_side,
    output logic [3:0][QB-1:0]   o_quo,
    output logic [SW-1:0]        o_side
);

    logic [DB-1:0] r_rem  [4][QB-1];
    logic [DB-1:0] r_den  [4][QB-1];
    logic [QB-1:0] r_nq   [4][QB];
    logic [SW-1:0] r_side [QB];

    genvar l, g;
    generate
        for (l = 0; l < 4; l++) begin : g_lane
            for (g = 0; g < QB; g++) begin : g_step
                logic [DB-1:0] rem_in, den_in, n_rem;
                logic [QB-1:0] nq_in;
                logic [DB:0]   t, d, diff;
                logic          ge;

                if (g == 0) begin : g_first
                    assign rem_in = '0;
                    assign den_in = i_den[l];
                    assign nq_in  = i_num[l];
                end else begin : g_next
                    assign rem_in = r_rem[l][g-1];
                    assign den_in = r_den[l][g-1];
                    assign nq_in  = r_nq[l][g-1];
                end

                always_comb begin
                    t     = {rem_in, nq_in[QB-1]};
                    d     = {1'b0, den_in};
                    diff  = t - d;
                    ge    = (t >= d);
                    n_rem = ge ? diff[DB-1:0] : t[DB-1:0];
                end

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_nq[l][g] <= {nq_in[QB-2:0], ge};
                    end
                end

                if (g < QB - 1) begin : g_carry
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_rem[l][g] <= n_rem;
                            r_den[l][g] <= den_in;
                        end
                    end
                end
            end
            assign o_quo[l] = r_nq[l][QB-1];
        end

        for (g = 0; g < QB; g++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[g] <= (g == 0) ? i_side : r_side[(g == 0) ? 0 : g-1];
                end
            end
        end
    endgenerate

    assign o_side = r_side[QB-1];

endmodule

// File: src/vec4_arithmetic_unit.sv
// Channel   Direction  Signals                      Content
// s_axis    in         tvalid, tready, tdata        command, a_x..a_w, b_x..b_w, scale_factor
// m_axis    out        tvalid, tready, tdata        r_x..r_w, scalar_result, div_zero, overflow
//
// One item is accepted per cycle while the output is not stalled.
// Each item passes through the lane registers, the merge register, the square root pipeline
// (one root bit per stage), the four-lane divider pipeline (one quotient bit per stage) and
// the output register.
// Reset clears only the valid bits of the pipeline and the output valid bit.
// While a result waits at the output, the whole pipeline holds and no item is accepted.
`timescale 1ns / 1ps

module vec4_arithmetic_unit #(
    parameter int COMPONENT_BITS = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor, zero padding
    input  logic [((v4au_pkg::CMD_W + 9*COMPONENT_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // r_x, r_y, r_z, r_w, scalar_result, div_zero, overflow, zero padding
    output logic [((5*COMPONENT_BITS + 2 + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int W     = COMPONENT_BITS;
    localparam int F     = FRACTION_BITS;
    localparam int RB    = W + 1;
    localparam int DB    = W + 1;
    localparam int QB    = W + F;
    localparam int NV    = 2 + RB + QB;
    localparam int CW    = v4au_pkg::CMD_W;
    localparam int OUT_W = ((5*W + 2 + 7) / 8) * 8;
    localparam logic [QB-1:0] LIM_POS = {{(QB-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = LIM_POS + 1'b1;

    typedef struct packed {
        v4au_pkg::t_cmd     cmd;
        logic [3:0]         an;
        logic [3:0]         bn;
        logic [3:0][W-1:0]  amag;
        logic [3:0][W-1:0]  bmag;
        logic [3:0][W-1:0]  pre;
        logic [W-1:0]       scal;
        logic               ovf;
    } t_side1;

    typedef struct packed {
        v4au_pkg::t_cmd     cmd;
        logic [3:0]         an;
        logic [3:0]         bn;
        logic [3:0]         bz;
        logic [3:0][W-1:0]  pre;
        logic [W-1:0]       scal;
        logic               ovf;
        logic [RB-1:0]      root;
    } t_side2;

    function automatic logic [W:0] f_sat(input logic [QB-1:0] m, input logic neg);
        logic [QB-1:0] lim;
        logic [QB-1:0] mm;
        logic          ovf;
        lim = neg ? LIM_NEG : LIM_POS;
        ovf = (m > lim);
        mm  = ovf ? lim : m;
        return {ovf, neg ? (~mm[W-1:0] + 1'b1) : mm[W-1:0]};
    endfunction

    logic                   en;
    logic [NV-1:0]          r_vld;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    v4au_pkg::t_cmd         in_cmd;
    logic [3:0][W-1:0]      in_a, in_b;
    logic [W-1:0]           in_scl;

    logic [3:0][W-1:0]      ln_addsub, ln_a_mag, ln_b_mag;
    logic [3:0]             ln_addsub_ovf, ln_prod_neg, ln_a_neg, ln_b_neg;
    logic [3:0][2*W-1:0]    ln_prod;

    v4au_pkg::t_cmd         r_cmd1, r_cmd2;
    logic [3:0]             r_an2, r_bn2;
    logic [3:0][W-1:0]      r_amag2, r_bmag2;

    logic [3:0][W-1:0]      mg_pre;
    logic [W-1:0]           mg_scal;
    logic                   mg_ovf;
    logic [2*W+1:0]         mg_sumsq;

    t_side1                 side1, s1o;
    logic [RB-1:0]          sq_root;
    t_side2                 side2, s2o;
    logic [3:0][QB-1:0]     dv_num, dv_quo;
    logic [3:0][DB-1:0]     dv_den;

    logic [3:0][W-1:0]      n_res;
    logic [W-1:0]           n_scal;
    logic                   n_dz, n_ovf;
    logic [W:0]             q_sat;
    logic [OUT_W-1:0]       n_data;

    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_cmd = v4au_pkg::t_cmd'(i_s_axis_tdata[CW-1:0]);
    assign in_scl = i_s_axis_tdata[CW + 8*W +: W];

    genvar l;
    generate
        for (l = 0; l < 4; l++) begin : g_lane
            assign in_a[l] = i_s_axis_tdata[CW + l*W +: W];
            assign in_b[l] = i_s_axis_tdata[CW + (4+l)*W +: W];

            v4au_lane #(.W(W)) u_lane (
                .i_clk        (i_clk),
                .i_en         (en),
                .i_cmd        (in_cmd),
                .i_a          (in_a[l]),
                .i_b          (in_b[l]),
                .i_scl        (in_scl),
                .o_addsub     (ln_addsub[l]),
                .o_addsub_ovf (ln_addsub_ovf[l]),
                .o_prod       (ln_prod[l]),
                .o_prod_neg   (ln_prod_neg[l]),
                .o_a_mag      (ln_a_mag[l]),
                .o_a_neg      (ln_a_neg[l]),
                .o_b_mag      (ln_b_mag[l]),
                .o_b_neg      (ln_b_neg[l])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1  <= in_cmd;
            r_cmd2  <= r_cmd1;
            r_an2   <= ln_a_neg;
            r_bn2   <= ln_b_neg;
            r_amag2 <= ln_a_mag;
            r_bmag2 <= ln_b_mag;
        end
    end

    v4au_merge #(.W(W), .F(F)) u_merge (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_cmd        (r_cmd1),
        .i_addsub     (ln_addsub),
        .i_addsub_ovf (ln_addsub_ovf),
        .i_prod       (ln_prod),
        .i_prod_neg   (ln_prod_neg),
        .o_pre        (mg_pre),
        .o_scal       (mg_scal),
        .o_ovf        (mg_ovf),
        .o_sumsq      (mg_sumsq)
    );

    always_comb begin
        side1.cmd  = r_cmd2;
        side1.an   = r_an2;
        side1.bn   = r_bn2;
        side1.amag = r_amag2;
        side1.bmag = r_bmag2;
        side1.pre  = mg_pre;
        side1.scal = mg_scal;
        side1.ovf  = mg_ovf;
    end

    v4au_sqrt #(.RB(RB), .SW($bits(t_side1))) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (mg_sumsq),
        .i_side (side1),
        .o_root (sq_root),
        .o_side (s1o)
    );

    // Normalize divides by the unsaturated magnitude, divide by the magnitude of B.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dv_num[i] = {s1o.amag[i], {F{1'b0}}};
            dv_den[i] = (s1o.cmd == v4au_pkg::CMD_DIV) ? {1'b0, s1o.bmag[i]} : sq_root;
            side2.bz[i] = (s1o.bmag[i] == '0);
        end
        side2.cmd  = s1o.cmd;
        side2.an   = s1o.an;
        side2.bn   = s1o.bn;
        side2.pre  = s1o.pre;
        side2.scal = s1o.scal;
        side2.ovf  = s1o.ovf;
        side2.root = sq_root;
    end

    v4au_div #(.QB(QB), .DB(DB), .SW($bits(t_side2))) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (dv_num),
        .i_den  (dv_den),
        .i_side (side2),
        .o_quo  (dv_quo),
        .o_side (s2o)
    );

    always_comb begin
        n_res  = '0;
        n_scal = '0;
        n_dz   = 1'b0;
        n_ovf  = 1'b0;
        q_sat  = '0;
        case (s2o.cmd)
            v4au_pkg::CMD_DIV: begin
                for (int i = 0; i < 4; i++) begin
                    if (s2o.bz[i]) begin
                        n_dz = 1'b1;
                    end else begin
                        q_sat    = f_sat(dv_quo[i], s2o.an[i] ^ s2o.bn[i]);
                        n_res[i] = q_sat[W-1:0];
                        n_ovf    = n_ovf | q_sat[W];
                    end
                end
            end
            v4au_pkg::CMD_NORM: begin
                if (s2o.root == '0) begin
                    n_dz = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        q_sat    = f_sat(dv_quo[i], s2o.an[i]);
                        n_res[i] = q_sat[W-1:0];
                        n_ovf    = n_ovf | q_sat[W];
                    end
                end
            end
            v4au_pkg::CMD_MAG: begin
                q_sat  = f_sat(QB'(s2o.root), 1'b0);
                n_scal = q_sat[W-1:0];
                n_ovf  = q_sat[W];
            end
            default: begin
                n_res  = s2o.pre;
                n_scal = s2o.scal;
                n_ovf  = s2o.ovf;
            end
        endcase
        n_data = OUT_W'({n_ovf, n_dz, n_scal, n_res});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[NV-2:0], i_s_axis_tvalid};
            r_out_valid <= r_vld[NV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_data;
        end
    end

    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("Pipeline valid bits moved while the output was stalled.");

    a_scalar_or_vector : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out_data[4*W +: W] == '0 || r_out_data[4*W-1:0] == '0))
        else $error("Result carries both a scalar and a vector.");

    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid after reset.");

endmodule
